// File: rtl/prim_mst_pkg.sv
// ----------------------------------------------------------------------------
// prim_mst_pkg
// Shared types and constants for the Prim minimum spanning tree unit.
// ----------------------------------------------------------------------------
package prim_mst_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VERT_W       = 6;
  localparam int unsigned WEIGHT_W     = 14;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned ADJ_AW       = 2 * VERT_W;
  localparam int unsigned ADJ_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned CAND_DEPTH   = MAX_VERTICES - 1;

  localparam logic [WEIGHT_W-1:0] NO_EDGE_WEIGHT = WEIGHT_W'(10000);

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_EDGE  = 2'd1,
    ACT_RUN   = 2'd2
  } action_e;

  // candidate list entry
  typedef struct packed {
    logic [VERT_W-1:0]   from_v;
    logic [VERT_W-1:0]   to_v;
    logic [WEIGHT_W-1:0] weight;
  } cand_t;

  typedef struct packed {
    logic clear_init;
    logic clear_en;
    logic edge_wr;
    logic run_init;
    logic scan_en;
    logic emit;
  } mst_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic issue_last;
    logic pipe_busy;
    logic run_last;
  } mst_sts_t;

endpackage

// File: rtl/prim_mst_ctrl.sv
// ----------------------------------------------------------------------------
// prim_mst_ctrl
// Sequencer for clear sweeps, edge writes and tree runs.
// ----------------------------------------------------------------------------
module prim_mst_ctrl import prim_mst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [1:0]  action_i,
  input  mst_sts_t    sts_i,
  output mst_cmd_t    cmd_o,
  output logic        busy
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACT_CLEAR) begin
            cmd_o.clear_init = 1'b1;
            state_d          = ST_CLEAR;
          end else if (action_i == ACT_EDGE) begin
            cmd_o.edge_wr = 1'b1;
          end else if (action_i == ACT_RUN) begin
            cmd_o.run_init = 1'b1;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.run_last ? ST_IDLE : ST_SCAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/prim_mst_dp.sv
// ----------------------------------------------------------------------------
// prim_mst_dp
// Adjacency and candidate memories, scan pipeline and minimum tracking.
// ----------------------------------------------------------------------------
module prim_mst_dp import prim_mst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mst_cmd_t            cmd_i,
  output mst_sts_t            sts_o,
  input  logic [VERT_W-1:0]   vertex_a_i,
  input  logic [VERT_W-1:0]   vertex_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  input  logic [VERT_W-1:0]   last_pos_i,
  output logic                result_valid_o,
  output logic [VERT_W-1:0]   from_vertex_o,
  output logic [VERT_W-1:0]   to_vertex_o,
  output logic [WEIGHT_W-1:0] tree_weight_o,
  output logic                last_o
);

  // the matrix stays symmetric, so only the (low, high) entry is used
  function automatic logic [ADJ_AW-1:0] pair_addr(input logic [VERT_W-1:0] x,
                                                  input logic [VERT_W-1:0] y);
    logic [ADJ_AW-1:0] addr;
    if (x <= y) addr = {x, y};
    else        addr = {y, x};
    return addr;
  endfunction

  logic [WEIGHT_W-1:0] adj_mem [ADJ_DEPTH];
  cand_t               cand_mem [CAND_DEPTH];

  logic [ADJ_AW-1:0]   clr_addr_q, clr_addr_d;
  logic [VERT_W-1:0]   k_q, k_d;
  logic [VERT_W-1:0]   i_q, i_d;
  logic                init_q, init_d;
  logic [VERT_W-1:0]   nv_q, nv_d;
  logic                s1_valid_q, s2_valid_q;
  logic                res_valid_q;

  logic [VERT_W-1:0]   s1_idx_q, s2_idx_q;
  cand_t               cand_rd_q;
  cand_t               s2_entry_q;
  logic [WEIGHT_W-1:0] adj_rd_q;
  cand_t               best_q, head_q;
  logic [VERT_W-1:0]   best_pos_q;
  logic [WEIGHT_W-1:0] minw_q;

  // adjacency write and read
  logic                adj_we;
  logic [ADJ_AW-1:0]   adj_waddr;
  logic [WEIGHT_W-1:0] adj_wdata;
  logic [VERT_W-1:0]   s1_to;
  logic [ADJ_AW-1:0]   adj_raddr;
  cand_t               s1_entry;

  always_comb begin
    adj_we    = cmd_i.clear_en | cmd_i.edge_wr;
    adj_waddr = pair_addr(vertex_a_i, vertex_b_i);
    adj_wdata = edge_weight_i;
    if (cmd_i.clear_en) begin
      adj_waddr = clr_addr_q;
      adj_wdata = (clr_addr_q[ADJ_AW-1:VERT_W] == clr_addr_q[VERT_W-1:0]) ? '0
                                                                         : NO_EDGE_WEIGHT;
    end
  end

  // stage 1: on the first scan the candidate list is built from row 0
  always_comb begin
    s1_to     = init_q ? VERT_W'(s1_idx_q + 1'b1) : cand_rd_q.to_v;
    adj_raddr = pair_addr(nv_q, s1_to);
    s1_entry  = cand_rd_q;
    if (init_q) begin
      s1_entry.from_v = '0;
      s1_entry.to_v   = s1_to;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rd_q <= adj_mem[adj_raddr];
  end

  // stage 2: relax against the newest tree vertex
  cand_t s2_new;
  logic  first_elem;

  always_comb begin
    s2_new = s2_entry_q;
    if (init_q || (adj_rd_q < s2_entry_q.weight)) begin
      s2_new.from_v = nv_q;
      s2_new.weight = adj_rd_q;
    end
    first_elem = (s2_idx_q == k_q);
  end

  // candidate memory: one write port shared by stage 2 and the swap
  logic              cand_we;
  logic [VERT_W-1:0] cand_waddr;
  cand_t             cand_wdata;

  always_comb begin
    cand_we    = s2_valid_q | cmd_i.emit;
    cand_waddr = cmd_i.emit ? best_pos_q : s2_idx_q;
    cand_wdata = cmd_i.emit ? head_q : s2_new;
  end

  always_ff @(posedge clk_i) begin
    if (cand_we) cand_mem[cand_waddr] <= cand_wdata;
    cand_rd_q <= cand_mem[i_q];
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_idx_q   <= i_q;
    s2_idx_q   <= s1_idx_q;
    s2_entry_q <= s1_entry;
    if (s2_valid_q) begin
      if (first_elem) begin
        head_q     <= s2_new;
        best_q     <= s2_new;
        best_pos_q <= s2_idx_q;
        minw_q     <= (s2_new.weight < NO_EDGE_WEIGHT) ? s2_new.weight : NO_EDGE_WEIGHT;
      end else if (s2_new.weight < minw_q) begin
        best_q     <= s2_new;
        best_pos_q <= s2_idx_q;
        minw_q     <= s2_new.weight;
      end
    end
    if (cmd_i.emit) begin
      from_vertex_o <= best_q.from_v;
      to_vertex_o   <= best_q.to_v;
      tree_weight_o <= best_q.weight;
      last_o        <= (k_q == last_pos_i);
    end
  end

  // control counters
  always_comb begin
    clr_addr_d = clr_addr_q;
    k_d        = k_q;
    i_d        = i_q;
    init_d     = init_q;
    nv_d       = nv_q;
    if (cmd_i.clear_init) clr_addr_d = '0;
    if (cmd_i.clear_en)   clr_addr_d = ADJ_AW'(clr_addr_q + 1'b1);
    if (cmd_i.run_init) begin
      k_d    = '0;
      i_d    = '0;
      init_d = 1'b1;
      nv_d   = '0;
    end
    if (cmd_i.scan_en) i_d = VERT_W'(i_q + 1'b1);
    if (cmd_i.emit) begin
      k_d    = VERT_W'(k_q + 1'b1);
      i_d    = VERT_W'(k_q + 1'b1);
      init_d = 1'b0;
      nv_d   = best_q.to_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      k_q         <= '0;
      i_q         <= '0;
      init_q      <= 1'b0;
      nv_q        <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      clr_addr_q  <= clr_addr_d;
      k_q         <= k_d;
      i_q         <= i_d;
      init_q      <= init_d;
      nv_q        <= nv_d;
      s1_valid_q  <= cmd_i.scan_en;
      s2_valid_q  <= s1_valid_q;
      res_valid_q <= cmd_i.emit;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign sts_o.clear_last = &clr_addr_q;
  assign sts_o.issue_last = (i_q == last_pos_i);
  assign sts_o.pipe_busy  = s1_valid_q | s2_valid_q;
  assign sts_o.run_last   = (k_q == last_pos_i);

endmodule

// File: rtl/prim_minimum_spanning_tree_unit.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_unit
// Prim minimum spanning tree over a 64-vertex adjacency matrix.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. An edge item leaves busy
// low, so edge items may follow one per cycle. A clear item holds busy while
// the matrix is swept one entry per cycle. A run item over n vertices holds
// busy while each of its n-1 tree steps scans the remaining candidates one
// per cycle through a read pipeline on the candidate and matrix memories,
// waits for the pipeline to drain, then swaps and emits. Each tree edge is
// shown for exactly one cycle with result_valid_o high and must be taken
// then; last_o marks the final edge of the run. The user must write the
// vertex count register over the APB port only while busy is low; the block
// itself does not enforce it.
module prim_minimum_spanning_tree_unit import prim_mst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action_i,
  input  logic [VERT_W-1:0]   vertex_a_i,
  input  logic [VERT_W-1:0]   vertex_b_i,
  input  logic [WEIGHT_W-1:0] edge_weight_i,
  // results
  output logic                result_valid_o,
  output logic [VERT_W-1:0]   from_vertex_o,
  output logic [VERT_W-1:0]   to_vertex_o,
  output logic [WEIGHT_W-1:0] tree_weight_o,
  output logic                last_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [COUNT_W-1:0] vertex_count_q;
  logic [COUNT_W-1:0] active_count;
  logic [VERT_W-1:0]  last_pos;
  logic               cfg_wr;
  mst_cmd_t           cmd;
  mst_sts_t           sts;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= COUNT_W'(MAX_VERTICES);
    end else if (cfg_wr) begin
      vertex_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {{(32-COUNT_W){1'b0}}, vertex_count_q} : '0;

  // out-of-range counts are clamped to 2..64
  always_comb begin
    active_count = vertex_count_q;
    if (vertex_count_q < COUNT_W'(2))            active_count = COUNT_W'(2);
    if (vertex_count_q > COUNT_W'(MAX_VERTICES)) active_count = COUNT_W'(MAX_VERTICES);
    last_pos = VERT_W'(active_count - COUNT_W'(2));
  end

  prim_mst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  prim_mst_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .edge_weight_i  (edge_weight_i),
    .last_pos_i     (last_pos),
    .result_valid_o (result_valid_o),
    .from_vertex_o  (from_vertex_o),
    .to_vertex_o    (to_vertex_o),
    .tree_weight_o  (tree_weight_o),
    .last_o         (last_o)
  );

endmodule
